### src/euclidean_distance_accumulator_top_assert.svh
// Assertion macros used by the root unit of the distance accumulator.
`ifndef EUCLIDEAN_DISTANCE_ACCUMULATOR_TOP_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_ACCUMULATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/edacc_pkg.sv
// Shared types and constants of the Euclidean distance accumulator.
`timescale 1ns / 1ps
package edacc_pkg;

  localparam int ELEM_W = 16;
  localparam int MAG_W  = ELEM_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 44;
  localparam int DIST_W = 22;
  localparam int REM_W  = DIST_W + 3;
  localparam int CNT_W  = $clog2(DIST_W);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // One finished vector sum handed from the front end to the root unit.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             sat;
  } sum_entry_t;

  // Handshake between the queue and the root unit.
  typedef struct packed {
    logic       empty;
    sum_entry_t head;
  } queue_rd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DONE = 3'b100
  } root_state_e;

endpackage

### src/euclidean_distance_accumulator_top.sv
// Top level of the Euclidean distance accumulator.
//
//   channel | direction | handshake        | fields
//   --------+-----------+------------------+---------------------------------
//   input   | in        | push / full      | elem_a_i, elem_b_i, last_elem_i
//   result  | out       | empty / pop      | distance_o, sum_saturated_o
//
// One element pair is taken per cycle while full is low; the front end registers the
// magnitude, then the square. The root unit loads a sum, computes the root digits one
// per step, then writes the result register; short vectors back up through the two-entry queue.
// Reset clears the running sum, the saturation flag, the queue and the result valid flag.
// full rises only while a finished vector waits for a free queue entry.
`timescale 1ns / 1ps
module euclidean_distance_accumulator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [edacc_pkg::ELEM_W-1:0] elem_a_i,
  input  logic signed [edacc_pkg::ELEM_W-1:0] elem_b_i,
  input  logic                               last_elem_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [edacc_pkg::DIST_W-1:0]       distance_o,
  output logic                               sum_saturated_o
);
  import edacc_pkg::*;

  logic       q_full, q_push, q_pop;
  sum_entry_t q_wdata;
  queue_rd_t  q_rd;

  edacc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .last_elem_i (last_elem_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  edacc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rd_o   (q_rd)
  );

  edacc_sqrt u_sqrt (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_rd_i          (q_rd),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .distance_o      (distance_o),
    .sum_saturated_o (sum_saturated_o)
  );

endmodule

### src/edacc_front.sv
// Front end: difference, square and saturating accumulation of element pairs.
`timescale 1ns / 1ps
module edacc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic signed [edacc_pkg::ELEM_W-1:0] elem_a_i,
  input  logic signed [edacc_pkg::ELEM_W-1:0] elem_b_i,
  input  logic                           last_elem_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output edacc_pkg::sum_entry_t          q_data_o
);
  import edacc_pkg::*;

  logic                    s1_valid_q, s1_last_q;
  logic [MAG_W-1:0]        s1_mag_q;
  logic                    s2_valid_q, s2_last_q;
  logic [SQ_W-1:0]         s2_sq_q;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic                    sat_q, sat_d;
  logic signed [ELEM_W:0]  diff;
  logic [ELEM_W:0]         mag_full;
  logic [SUM_W:0]          sum_ext;
  logic                    stall, en, accept;

  // Only a finished vector needs room in the queue; everything else flows.
  assign stall  = s2_valid_q & s2_last_q & q_full_i;
  assign en     = ~stall;
  assign full_o = stall;
  assign accept = push_i & ~stall;

  assign diff     = {elem_a_i[ELEM_W-1], elem_a_i} - {elem_b_i[ELEM_W-1], elem_b_i};
  assign mag_full = diff[ELEM_W] ? -diff : diff;

  assign sum_ext = {1'b0, sum_q} + {{(SUM_W + 1 - SQ_W){1'b0}}, s2_sq_q};

  always_comb begin
    if (sum_ext[SUM_W]) begin
      sum_d = SUM_MAX;
      sat_d = 1'b1;
    end else begin
      sum_d = sum_ext[SUM_W-1:0];
      sat_d = sat_q;
    end
  end

  assign q_push_o     = en & s2_valid_q & s2_last_q;
  assign q_data_o.sum = sum_d;
  assign q_data_o.sat = sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_last_q  <= 1'b0;
      sum_q      <= '0;
      sat_q      <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
      s1_last_q  <= last_elem_i;
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
      if (s2_valid_q) begin
        if (s2_last_q) begin
          sum_q <= '0;
          sat_q <= 1'b0;
        end else begin
          sum_q <= sum_d;
          sat_q <= sat_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mag_q <= mag_full[MAG_W-1:0];
      s2_sq_q  <= s1_mag_q * s1_mag_q;
    end
  end

endmodule

### src/edacc_fifo.sv
// Short queue of finished vector sums between the front end and the root unit.
`timescale 1ns / 1ps
module edacc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  edacc_pkg::sum_entry_t data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output edacc_pkg::queue_rd_t  rd_o
);
  import edacc_pkg::*;

  sum_entry_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign rd_o.empty   = (cnt_q == '0);
  assign rd_o.head    = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & ~rd_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/edacc_sqrt.sv
// Back end: digit-by-digit floor square root and the result register.
`timescale 1ns / 1ps
`include "euclidean_distance_accumulator_top_assert.svh"
module edacc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edacc_pkg::queue_rd_t        q_rd_i,
  output logic                        q_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [edacc_pkg::DIST_W-1:0] distance_o,
  output logic                        sum_saturated_o
);
  import edacc_pkg::*;

  root_state_e       state_q, state_d;
  logic [SUM_W-1:0]  x_q;
  logic [REM_W-1:0]  rem_q, rem_sh, trial, rem_d;
  logic [DIST_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              sat_q, ge;
  logic              out_valid_q, out_take, load_out;

  // Two bits of the sum enter the partial remainder per step.
  assign rem_sh = {rem_q[REM_W-3:0], x_q[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign rem_d  = ge ? rem_sh - trial : rem_sh;
  assign root_d = {root_q[DIST_W-2:0], ge};

  assign out_take = pop_i & out_valid_q;
  assign load_out = (state_q == S_DONE) & (~out_valid_q | out_take);
  assign q_pop_o  = (state_q == S_IDLE) & ~q_rd_i.empty;
  assign empty_o  = ~out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!q_rd_i.empty) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (q_pop_o) begin
        cnt_q <= CNT_W'(DIST_W - 1);
      end else if (state_q == S_CALC) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      x_q    <= q_rd_i.head.sum;
      sat_q  <= q_rd_i.head.sat;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == S_CALC) begin
      x_q    <= {x_q[SUM_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
    if (load_out) begin
      distance_o      <= root_q;
      sum_saturated_o <= sat_q;
    end
  end

  `EDA_ASSERT_NEXT(a_calc_runs, (state_q == S_CALC) && (cnt_q != '0), state_q == S_CALC, "root iteration left early")
  `EDA_ASSERT_NOW(a_pop_when_idle, q_pop_o, (state_q == S_IDLE) && !q_rd_i.empty, "queue read outside idle")
  `EDA_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "result loaded without a finished root")

endmodule
